// ===== design/ptc_pkg.sv =====
// Shared types, codes and the arrow image for the pointer tracker.
package ptc_pkg;

  localparam int CURSOR_W = 16;
  localparam int CURSOR_H = 16;
  localparam int ROW_W    = $clog2(CURSOR_H);

  localparam logic [12:0] SCREEN_MAX = 13'd4096;
  localparam logic [12:0] WIDTH_RST  = 13'd1920;
  localparam logic [12:0] HEIGHT_RST = 13'd1080;
  localparam logic [11:0] CX_RST     = 12'd960;
  localparam logic [11:0] CY_RST     = 12'd540;

  localparam logic [1:0] ACT_REPORT = 2'd0;
  localparam logic [1:0] ACT_SETPOS = 2'd1;
  localparam logic [1:0] ACT_DRAW   = 2'd2;

  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_VISIBLE = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ROW    = 1'b1;

  // Arrow image as per-row masks: opaque covers black and white pixels.
  localparam logic [CURSOR_W-1:0] ARROW_OPAQUE [CURSOR_H] = '{
    16'h0003, 16'h0007, 16'h000F, 16'h001F, 16'h003F, 16'h007F, 16'h00FF, 16'h01FF,
    16'h03FF, 16'h07FF, 16'h07FF, 16'h007F, 16'h00F7, 16'h00F3, 16'h01E1, 16'h00E0
  };
  localparam logic [CURSOR_W-1:0] ARROW_WHITE [CURSOR_H] = '{
    16'h0000, 16'h0002, 16'h0006, 16'h000E, 16'h001E, 16'h003E, 16'h007E, 16'h00FE,
    16'h01FE, 16'h03FE, 16'h003E, 16'h0036, 16'h0062, 16'h0060, 16'h00C0, 16'h0000
  };

  typedef struct packed {
    logic capture;
    logic execute;
    logic load_status;
    logic load_row;
  } cmd_t;

  typedef struct packed {
    logic draw_go;
    logic row_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/ptc_ctrl.sv =====
// Controller state machine that sequences transactions through the datapath.
module ptc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ptc_pkg::sts_t sts,
  output ptc_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_STATUS = 4'b0100,
    S_DRAW   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    cmd.capture     = 1'b0;
    cmd.execute     = 1'b0;
    cmd.load_status = 1'b0;
    cmd.load_row    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = sts.draw_go ? S_DRAW : S_STATUS;
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.load_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_DRAW: begin
        if (sts.out_free) begin
          cmd.load_row = 1'b1;
          if (sts.row_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Execution always lasts exactly one cycle.
  a_exec_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_DRAW || state_r == S_STATUS)
    else $error("exec state lasted more than one cycle");

  // A new transaction is only accepted after the last result has been loaded.
  a_draw_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW && !(cmd.load_row && sts.row_last)) |=> state_r == S_DRAW)
    else $error("draw sequence left before its last row");

  a_no_double_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_row && cmd.load_status) && !(cmd.capture && cmd.execute))
    else $error("conflicting datapath commands");

endmodule

// ===== design/ptc_dp.sv =====
// Datapath: configuration, pointer state, row sequencing and the output register.
module ptc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_wdata,
  input  logic [1:0]          in_action,
  input  logic signed [7:0]   in_move_x,
  input  logic signed [7:0]   in_move_y,
  input  logic [7:0]          in_button_bits,
  input  logic signed [7:0]   in_wheel_step,
  input  logic [11:0]         in_new_x,
  input  logic [11:0]         in_new_y,
  input  ptc_pkg::cmd_t       cmd,
  output ptc_pkg::sts_t       sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [11:0]         out_pos_x,
  output logic [11:0]         out_pos_y,
  output logic [7:0]          out_held_buttons,
  output logic signed [7:0]   out_last_wheel,
  output logic signed [7:0]   out_last_move_x,
  output logic signed [7:0]   out_last_move_y,
  output logic [3:0]          out_row_index,
  output logic [15:0]         out_opaque_mask,
  output logic [15:0]         out_white_mask,
  output logic                out_last
);

  localparam int RW = ptc_pkg::ROW_W;
  localparam int CW = ptc_pkg::CURSOR_W;

  // Configuration.
  logic [12:0] width_r, height_r;
  logic        visible_r;

  // Captured transaction.
  logic [1:0]  act_r;
  logic [7:0]  mx_r, my_r, btn_in_r, whl_in_r;
  logic [11:0] nx_r, ny_r;

  // Pointer state.
  logic [11:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic [7:0]  btn_r, whl_r, dx_r, dy_r;

  // Draw sequencing.
  logic [CW-1:0] clip_r, clip_nxt;
  logic [RW-1:0] row_r, last_row_r, last_row_nxt;

  // Output register.
  logic          ovalid_r;
  logic          okind_r, olast_r;
  logic [11:0]   ox_r, oy_r;
  logic [7:0]    obtn_r, owhl_r, odx_r, ody_r;
  logic [RW-1:0] orow_r;
  logic [CW-1:0] oopq_r, owht_r;

  logic [12:0] w_eff, h_eff;
  logic [13:0] sum_x, sum_y;
  logic [12:0] rows_left;
  logic [12:0] col_x;
  logic        load;

  always_comb begin
    w_eff = (width_r == 13'd0) ? 13'd1 :
            (width_r > ptc_pkg::SCREEN_MAX) ? ptc_pkg::SCREEN_MAX : width_r;
    h_eff = (height_r == 13'd0) ? 13'd1 :
            (height_r > ptc_pkg::SCREEN_MAX) ? ptc_pkg::SCREEN_MAX : height_r;
  end

  // Next position: clamped movement or a checked position set; sums are 14-bit two's complement.
  always_comb begin
    sum_x = {2'b00, cx_r} + {{6{mx_r[7]}}, mx_r};
    sum_y = {2'b00, cy_r} + {{6{my_r[7]}}, my_r};
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    case (act_r)
      ptc_pkg::ACT_REPORT: begin
        if (sum_x[13]) begin
          cx_nxt = 12'd0;
        end else if (sum_x[12:0] >= w_eff) begin
          cx_nxt = 12'(w_eff - 13'd1);
        end else begin
          cx_nxt = sum_x[11:0];
        end
        if (sum_y[13]) begin
          cy_nxt = 12'd0;
        end else if (sum_y[12:0] >= h_eff) begin
          cy_nxt = 12'(h_eff - 13'd1);
        end else begin
          cy_nxt = sum_y[11:0];
        end
      end
      ptc_pkg::ACT_SETPOS: begin
        if ({1'b0, nx_r} < w_eff && {1'b0, ny_r} < h_eff) begin
          cx_nxt = nx_r;
          cy_nxt = ny_r;
        end
      end
      default: begin
        cx_nxt = cx_r;
        cy_nxt = cy_r;
      end
    endcase
  end

  // Draw setup: right-edge clip mask and the index of the final visible row.
  always_comb begin
    for (int c = 0; c < CW; c++) begin
      col_x       = {1'b0, cx_r} + 13'(c);
      clip_nxt[c] = col_x < w_eff;
    end
    col_x        = {1'b0, cx_r};
    rows_left    = h_eff - {1'b0, cy_r};
    last_row_nxt = (rows_left >= 13'(ptc_pkg::CURSOR_H)) ?
                   RW'(ptc_pkg::CURSOR_H - 1) : RW'(rows_left - 13'd1);
  end

  assign load         = cmd.load_status || cmd.load_row;
  assign sts.draw_go  = (act_r == ptc_pkg::ACT_DRAW) && visible_r && ({1'b0, cy_r} < h_eff);
  assign sts.row_last = (row_r == last_row_r);
  assign sts.out_free = !ovalid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= ptc_pkg::WIDTH_RST;
      height_r  <= ptc_pkg::HEIGHT_RST;
      visible_r <= 1'b1;
      cx_r      <= ptc_pkg::CX_RST;
      cy_r      <= ptc_pkg::CY_RST;
      btn_r     <= 8'd0;
      whl_r     <= 8'd0;
      dx_r      <= 8'd0;
      dy_r      <= 8'd0;
      ovalid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ptc_pkg::REG_WIDTH:   width_r   <= cfg_wdata;
          ptc_pkg::REG_HEIGHT:  height_r  <= cfg_wdata;
          ptc_pkg::REG_VISIBLE: visible_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.execute) begin
        cx_r <= cx_nxt;
        cy_r <= cy_nxt;
        if (act_r == ptc_pkg::ACT_REPORT) begin
          btn_r <= btn_in_r;
          whl_r <= whl_in_r;
          dx_r  <= mx_r;
          dy_r  <= my_r;
        end
      end
      if (load) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r    <= in_action;
      mx_r     <= in_move_x;
      my_r     <= in_move_y;
      btn_in_r <= in_button_bits;
      whl_in_r <= in_wheel_step;
      nx_r     <= in_new_x;
      ny_r     <= in_new_y;
    end
    if (cmd.execute) begin
      clip_r     <= clip_nxt;
      last_row_r <= last_row_nxt;
      row_r      <= '0;
    end else if (cmd.load_row) begin
      row_r <= row_r + RW'(1);
    end
    if (load) begin
      ox_r   <= cx_r;
      oy_r   <= cy_r;
      obtn_r <= btn_r;
      owhl_r <= whl_r;
      odx_r  <= dx_r;
      ody_r  <= dy_r;
      if (cmd.load_row) begin
        okind_r <= ptc_pkg::KIND_ROW;
        orow_r  <= row_r;
        oopq_r  <= ptc_pkg::ARROW_OPAQUE[row_r] & clip_r;
        owht_r  <= ptc_pkg::ARROW_WHITE[row_r] & clip_r;
        olast_r <= sts.row_last;
      end else begin
        okind_r <= ptc_pkg::KIND_STATUS;
        orow_r  <= '0;
        oopq_r  <= '0;
        owht_r  <= '0;
        olast_r <= 1'b1;
      end
    end
  end

  assign out_valid        = ovalid_r;
  assign out_kind         = okind_r;
  assign out_pos_x        = ox_r;
  assign out_pos_y        = oy_r;
  assign out_held_buttons = obtn_r;
  assign out_last_wheel   = owhl_r;
  assign out_last_move_x  = odx_r;
  assign out_last_move_y  = ody_r;
  assign out_row_index    = orow_r;
  assign out_opaque_mask  = oopq_r;
  assign out_white_mask   = owht_r;
  assign out_last         = olast_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!ovalid_r || out_ready))
    else $error("output register overwritten while holding a result");

  a_white_in_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (owht_r & ~oopq_r) == '0)
    else $error("white pixel outside the opaque mask");

  a_status_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && okind_r == ptc_pkg::KIND_STATUS) |-> (oopq_r == '0 && olast_r))
    else $error("status result carries row data or lacks last");

endmodule

// ===== design/pointer_tracker_with_cursor_sprite_top.sv =====
// Pointer tracker with a 16x16 arrow cursor: a report or a position request goes
// through capture, execute and load to its single status result; a draw request goes
// through capture and execute and then loads up to 16 row results from the row sequencer,
// one per cycle while the output side does not stall, or one status result if the
// cursor is hidden or below the screen. A new transaction is accepted once the last
// result of the previous one sits in the output register, even if it has not yet been
// taken. Configuration writes take effect at once and are meant for idle periods only.
module pointer_tracker_with_cursor_sprite_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic signed [7:0] in_move_x,
  input  logic signed [7:0] in_move_y,
  input  logic [7:0]        in_button_bits,
  input  logic signed [7:0] in_wheel_step,
  input  logic [11:0]       in_new_x,
  input  logic [11:0]       in_new_y,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [11:0]       out_pos_x,
  output logic [11:0]       out_pos_y,
  output logic [7:0]        out_held_buttons,
  output logic signed [7:0] out_last_wheel,
  output logic signed [7:0] out_last_move_x,
  output logic signed [7:0] out_last_move_y,
  output logic [3:0]        out_row_index,
  output logic [15:0]       out_opaque_mask,
  output logic [15:0]       out_white_mask,
  output logic              out_last
);

  ptc_pkg::cmd_t cmd;
  ptc_pkg::sts_t sts;

  ptc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_action        (in_action),
    .in_move_x        (in_move_x),
    .in_move_y        (in_move_y),
    .in_button_bits   (in_button_bits),
    .in_wheel_step    (in_wheel_step),
    .in_new_x         (in_new_x),
    .in_new_y         (in_new_y),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_held_buttons (out_held_buttons),
    .out_last_wheel   (out_last_wheel),
    .out_last_move_x  (out_last_move_x),
    .out_last_move_y  (out_last_move_y),
    .out_row_index    (out_row_index),
    .out_opaque_mask  (out_opaque_mask),
    .out_white_mask   (out_white_mask),
    .out_last         (out_last)
  );

endmodule

// ===== bench/pointer_tracker_with_cursor_sprite_top_tb.sv =====
// Self-checking testbench for the pointer tracker with its 16x16 arrow cursor.
`timescale 1ns / 1ps

typedef struct packed {
  logic [1:0]  action;
  logic [7:0]  move_x;
  logic [7:0]  move_y;
  logic [7:0]  button_bits;
  logic [7:0]  wheel_step;
  logic [11:0] new_x;
  logic [11:0] new_y;
} pointer_req_t;

typedef struct packed {
  logic        kind;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [7:0]  held_buttons;
  logic [7:0]  last_wheel;
  logic [7:0]  last_move_x;
  logic [7:0]  last_move_y;
  logic [3:0]  row_index;
  logic [15:0] opaque_mask;
  logic [15:0] white_mask;
  logic        last;
} cursor_item_t;

// Mirrors the pointer state and screen geometry, and holds the items still owed.
class pointer_mirror;
  logic [12:0]  width_reg;
  logic [12:0]  height_reg;
  logic         visible_reg;
  int           cur_x;
  int           cur_y;
  logic [7:0]   buttons;
  logic [7:0]   wheel;
  logic [7:0]   step_x;
  logic [7:0]   step_y;
  string        arrow_art [ptc_pkg::CURSOR_H];
  cursor_item_t due_items [$];
  int           errors;

  function new();
    // B is a black pixel, W a white one, a dot is transparent.
    arrow_art = '{
      "BB..............", "BWB.............", "BWWB............", "BWWWB...........",
      "BWWWWB..........", "BWWWWWB.........", "BWWWWWWB........", "BWWWWWWWB.......",
      "BWWWWWWWWB......", "BWWWWWWWWWB.....", "BWWWWWBBBBB.....", "BWWBWWB.........",
      "BWB.BWWB........", "BB..BWWB........", "B....BWWB.......", ".....BBB........"
    };
    width_reg   = ptc_pkg::WIDTH_RST;
    height_reg  = ptc_pkg::HEIGHT_RST;
    visible_reg = 1'b1;
    cur_x       = int'(ptc_pkg::CX_RST);
    cur_y       = int'(ptc_pkg::CY_RST);
    buttons     = 8'd0;
    wheel       = 8'd0;
    step_x      = 8'd0;
    step_y      = 8'd0;
    errors      = 0;
  endfunction

  function int span(logic [12:0] size);
    if (size == 13'd0) return 1;
    if (size > ptc_pkg::SCREEN_MAX) return int'(ptc_pkg::SCREEN_MAX);
    return int'(size);
  endfunction

  function int eff_width();
    return span(width_reg);
  endfunction

  function int eff_height();
    return span(height_reg);
  endfunction

  function int pending();
    return due_items.size();
  endfunction

  function void set_reg(logic [1:0] index, logic [12:0] value);
    case (index)
      ptc_pkg::REG_WIDTH:   width_reg = value;
      ptc_pkg::REG_HEIGHT:  height_reg = value;
      ptc_pkg::REG_VISIBLE: visible_reg = value[0];
      default: ;
    endcase
  endfunction

  function int clamp_axis(int pos, int delta, int size);
    int p;
    p = pos + delta;
    if (p < 0) p = 0;
    if (p >= size) p = size - 1;
    return p;
  endfunction

  function void owe_item(logic kind, logic [3:0] row, logic [15:0] opaque,
                         logic [15:0] white, logic last);
    cursor_item_t it;
    it.kind         = kind;
    it.pos_x        = 12'(cur_x);
    it.pos_y        = 12'(cur_y);
    it.held_buttons = buttons;
    it.last_wheel   = wheel;
    it.last_move_x  = step_x;
    it.last_move_y  = step_y;
    it.row_index    = row;
    it.opaque_mask  = opaque;
    it.white_mask   = white;
    it.last         = last;
    due_items.push_back(it);
  endfunction

  function void take_request(pointer_req_t req);
    int          w;
    int          h;
    int          rows;
    logic [15:0] opaque;
    logic [15:0] white;
    bit          drew;
    w    = eff_width();
    h    = eff_height();
    drew = 1'b0;
    case (req.action)
      ptc_pkg::ACT_REPORT: begin
        step_x  = req.move_x;
        step_y  = req.move_y;
        buttons = req.button_bits;
        wheel   = req.wheel_step;
        cur_x   = clamp_axis(cur_x, int'($signed(req.move_x)), w);
        cur_y   = clamp_axis(cur_y, int'($signed(req.move_y)), h);
      end
      ptc_pkg::ACT_SETPOS: begin
        if (int'(req.new_x) < w && int'(req.new_y) < h) begin
          cur_x = int'(req.new_x);
          cur_y = int'(req.new_y);
        end
      end
      ptc_pkg::ACT_DRAW: begin
        // A cursor entirely below the screen falls through to a status item.
        if (visible_reg && cur_y < h) begin
          rows = (h - cur_y > ptc_pkg::CURSOR_H) ? ptc_pkg::CURSOR_H : h - cur_y;
          for (int r = 0; r < rows; r++) begin
            opaque = 16'd0;
            white  = 16'd0;
            for (int c = 0; c < ptc_pkg::CURSOR_W && cur_x + c < w; c++) begin
              if (arrow_art[r][c] == "B") begin
                opaque[c] = 1'b1;
              end else if (arrow_art[r][c] == "W") begin
                opaque[c] = 1'b1;
                white[c]  = 1'b1;
              end
            end
            owe_item(ptc_pkg::KIND_ROW, 4'(r), opaque, white, r == rows - 1);
          end
          drew = 1'b1;
        end
      end
      default: ;
    endcase
    if (!drew) owe_item(ptc_pkg::KIND_STATUS, 4'd0, 16'd0, 16'd0, 1'b1);
  endfunction

  function void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_item(cursor_item_t got);
    cursor_item_t want;
    if (due_items.size() == 0) begin
      $error("result with no transaction pending: kind %0d row %0d", got.kind, got.row_index);
      errors++;
      return;
    end
    want = due_items.pop_front();
    check_field("kind", 16'(want.kind), 16'(got.kind));
    check_field("pos_x", 16'(want.pos_x), 16'(got.pos_x));
    check_field("pos_y", 16'(want.pos_y), 16'(got.pos_y));
    check_field("held_buttons", 16'(want.held_buttons), 16'(got.held_buttons));
    check_field("last_wheel", 16'(want.last_wheel), 16'(got.last_wheel));
    check_field("last_move_x", 16'(want.last_move_x), 16'(got.last_move_x));
    check_field("last_move_y", 16'(want.last_move_y), 16'(got.last_move_y));
    check_field("row_index", 16'(want.row_index), 16'(got.row_index));
    check_field("opaque_mask", want.opaque_mask, got.opaque_mask);
    check_field("white_mask", want.white_mask, got.white_mask);
    check_field("last", 16'(want.last), 16'(got.last));
  endfunction
endclass

module pointer_tracker_with_cursor_sprite_top_tb;

  localparam logic [1:0] ACT_UNUSED      = 2'd3;
  localparam int         QUIET_LIMIT     = 1000;
  localparam int         HOLD_OFF_CYCLES = 120;
  localparam int         SETTLE_CYCLES   = 8;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [12:0]       cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_action;
  logic signed [7:0] in_move_x;
  logic signed [7:0] in_move_y;
  logic [7:0]        in_button_bits;
  logic signed [7:0] in_wheel_step;
  logic [11:0]       in_new_x;
  logic [11:0]       in_new_y;
  logic              out_valid;
  logic              out_ready;
  logic              out_kind;
  logic [11:0]       out_pos_x;
  logic [11:0]       out_pos_y;
  logic [7:0]        out_held_buttons;
  logic signed [7:0] out_last_wheel;
  logic signed [7:0] out_last_move_x;
  logic signed [7:0] out_last_move_y;
  logic [3:0]        out_row_index;
  logic [15:0]       out_opaque_mask;
  logic [15:0]       out_white_mask;
  logic              out_last;

  bit            steady = 1'b0;
  bit            hold_off_req = 1'b0;
  cursor_item_t  seen_item;
  pointer_mirror mirror = new();

  pointer_tracker_with_cursor_sprite_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always_comb begin
    seen_item = '{kind: out_kind, pos_x: out_pos_x, pos_y: out_pos_y,
                  held_buttons: out_held_buttons, last_wheel: out_last_wheel,
                  last_move_x: out_last_move_x, last_move_y: out_last_move_y,
                  row_index: out_row_index, opaque_mask: out_opaque_mask,
                  white_mask: out_white_mask, last: out_last};
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) mirror.check_item(seen_item);
  end

  // Mostly no gap, some short ones and now and then a long one.
  function automatic int idle_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pointer_req_t make_req(logic [1:0] action, int mx, int my, int btn,
                                            int whl, int nx, int ny);
    pointer_req_t r;
    r.action      = action;
    r.move_x      = 8'(mx);
    r.move_y      = 8'(my);
    r.button_bits = 8'(btn);
    r.wheel_step  = 8'(whl);
    r.new_x       = 12'(nx);
    r.new_y       = 12'(ny);
    return r;
  endfunction

  function automatic pointer_req_t random_request(int w, int h);
    pointer_req_t r;
    int           roll;
    roll          = $urandom_range(0, 99);
    r.move_x      = 8'($urandom_range(0, 255));
    r.move_y      = 8'($urandom_range(0, 255));
    r.button_bits = 8'($urandom_range(0, 255));
    r.wheel_step  = 8'($urandom_range(0, 255));
    r.new_x       = 12'($urandom_range(0, 4095));
    r.new_y       = 12'($urandom_range(0, 4095));
    if (roll < 30) begin
      r.action = ptc_pkg::ACT_REPORT;
    end else if (roll < 50) begin
      r.action = ptc_pkg::ACT_SETPOS;
      // Most position requests land on screen, many of them near the right or
      // bottom edge so that draws get clipped.
      if ($urandom_range(0, 3) != 0) begin
        r.new_x = 12'($urandom_range(0, w - 1));
        r.new_y = 12'($urandom_range(0, h - 1));
        if ($urandom_range(0, 2) == 0) r.new_x = 12'($urandom_range(w > 16 ? w - 16 : 0, w - 1));
        if ($urandom_range(0, 2) == 0) r.new_y = 12'($urandom_range(h > 16 ? h - 16 : 0, h - 1));
      end
    end else if (roll < 95) begin
      r.action = ptc_pkg::ACT_DRAW;
    end else begin
      r.action = ACT_UNUSED;
    end
    return r;
  endfunction

  task automatic push_request(input pointer_req_t r, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_action      = r.action;
    in_move_x      = r.move_x;
    in_move_y      = r.move_y;
    in_button_bits = r.button_bits;
    in_wheel_step  = r.wheel_step;
    in_new_x       = r.new_x;
    in_new_y       = r.new_y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.take_request(r);
  endtask

  task automatic push(input logic [1:0] action, input int mx, my, btn, whl, nx, ny);
    push_request(make_req(action, mx, my, btn, whl, nx, ny), idle_gap());
  endtask

  // Stop offering, let every owed result drain, then give the block time to go idle.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    mirror.set_reg(index, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_phase(input int width, height, input bit show, calm, squeeze,
                           input int count);
    settle();
    write_reg(ptc_pkg::REG_WIDTH, 13'(width));
    write_reg(ptc_pkg::REG_HEIGHT, 13'(height));
    write_reg(ptc_pkg::REG_VISIBLE, 13'(show));
    steady = calm;
    for (int n = 0; n < count; n++) begin
      if (squeeze && n == 3) hold_off_req = 1'b1;
      push_request(random_request(mirror.eff_width(), mirror.eff_height()), idle_gap());
    end
    steady = 1'b0;
  endtask

  initial begin : receiver
    int stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (hold_off_req) begin
          stall_left   = HOLD_OFF_CYCLES;
          hold_off_req = 1'b0;
        end else begin
          stall_left = idle_gap();
        end
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("pointer_tracker_with_cursor_sprite_top_tb: errors");
    $finish;
  end

  initial begin : stimulus
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = ptc_pkg::REG_WIDTH;
    cfg_wdata      = 13'd0;
    in_valid       = 1'b0;
    in_action      = ptc_pkg::ACT_REPORT;
    in_move_x      = 8'sd0;
    in_move_y      = 8'sd0;
    in_button_bits = 8'd0;
    in_wheel_step  = 8'sd0;
    in_new_x       = 12'd0;
    in_new_y       = 12'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Default 1920x1080 screen: extremes of the movement fields and clamping on
    // both sides, rejected positions, and a draw clipped at both edges.
    push(ptc_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0);
    push(ptc_pkg::ACT_REPORT, 127, -128, 255, -128, 0, 0);
    push(ptc_pkg::ACT_REPORT, -128, 127, 0, 127, 4095, 4095);
    push(ptc_pkg::ACT_SETPOS, 0, 0, 0, 0, 0, 0);
    push(ptc_pkg::ACT_REPORT, -5, -5, 'h5a, 1, 0, 0);
    push(ptc_pkg::ACT_SETPOS, 0, 0, 0, 0, 4095, 4095);
    push(ptc_pkg::ACT_SETPOS, 0, 0, 0, 0, 1919, 1079);
    push(ptc_pkg::ACT_REPORT, 100, 100, 'ha5, -1, 0, 0);
    push(ptc_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0);
    push(ACT_UNUSED, 55, -55, 'hff, 9, 17, 17);
    push(ptc_pkg::ACT_SETPOS, 0, 0, 0, 0, 1910, 1070);
    push(ptc_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0);
    push(ptc_pkg::ACT_SETPOS, 0, 0, 0, 0, 1920, 0);
    push(ptc_pkg::ACT_SETPOS, 0, 0, 0, 0, 100, 1000);

    // Screen shrunk below the cursor: the draw answers with a status item.
    settle();
    write_reg(ptc_pkg::REG_HEIGHT, 13'd500);
    push(ptc_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0);

    // Cursor right of a narrow screen: sixteen rows with empty masks.
    settle();
    write_reg(ptc_pkg::REG_HEIGHT, 13'd1080);
    write_reg(ptc_pkg::REG_WIDTH, 13'd50);
    push(ptc_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0);

    settle();
    write_reg(ptc_pkg::REG_VISIBLE, 13'd0);
    push(ptc_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0);
    push(ptc_pkg::ACT_REPORT, 3, -3, 'h0f, 2, 0, 0);

    // Zero-sized screen acts as one pixel.
    settle();
    write_reg(ptc_pkg::REG_WIDTH, 13'd0);
    write_reg(ptc_pkg::REG_HEIGHT, 13'd0);
    write_reg(ptc_pkg::REG_VISIBLE, 13'd1);
    push(ptc_pkg::ACT_REPORT, 0, 0, 'hf0, 0, 0, 0);
    push(ptc_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0);
    push(ptc_pkg::ACT_SETPOS, 0, 0, 0, 0, 0, 0);
    push(ptc_pkg::ACT_SETPOS, 0, 0, 0, 0, 1, 0);

    // Oversized screen acts as 4096 pixels.
    settle();
    write_reg(ptc_pkg::REG_WIDTH, 13'h1fff);
    write_reg(ptc_pkg::REG_HEIGHT, 13'h1fff);
    push(ptc_pkg::ACT_SETPOS, 0, 0, 0, 0, 4095, 4095);
    push(ptc_pkg::ACT_REPORT, 127, 127, 'h81, -7, 0, 0);
    push(ptc_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0);

    run_phase(int'(ptc_pkg::WIDTH_RST), int'(ptc_pkg::HEIGHT_RST), 1'b1, 1'b1, 1'b1, 60);
    run_phase($urandom_range(1, 40), $urandom_range(1, 40), 1'b1, 1'b0, 1'b0, 60);
    run_phase(4096, 4096, 1'b1, 1'b0, 1'b0, 58);
    run_phase(8191, 0, 1'b1, 1'b0, 1'b0, 56);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 1'b0, 1'b0, 1'b0, 56);
    run_phase($urandom_range(1, 64), $urandom_range(1, 4096), 1'b1, 1'b0, 1'b0, 60);

    settle();
    if (mirror.errors == 0 && mirror.pending() == 0)
      $display("pointer_tracker_with_cursor_sprite_top_tb: clean");
    else
      $display("pointer_tracker_with_cursor_sprite_top_tb: errors");
    $finish;
  end

endmodule
